// ===== design/rbk_pkg.sv =====
package rbk_pkg;

  localparam int ACTIVE_SIZE  = 16;
  localparam int RESERVE_SIZE = 16;
  localparam int ID_BITS      = 64;

  localparam int ACNT_W = $clog2(ACTIVE_SIZE + 1);
  localparam int RCNT_W = $clog2(RESERVE_SIZE + 1);
  localparam int AIDX_W = (ACTIVE_SIZE > 1) ? $clog2(ACTIVE_SIZE) : 1;
  localparam int RIDX_W = (RESERVE_SIZE > 1) ? $clog2(RESERVE_SIZE) : 1;
  localparam int SCAN_W = (ACNT_W > RCNT_W) ? ACNT_W : RCNT_W;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_ADD   = 2'd1;
  localparam logic [1:0] ACT_PONG  = 2'd2;
  localparam logic [1:0] ACT_SWEEP = 2'd3;

  localparam logic [3:0] STS_TICKED     = 4'd0;
  localparam logic [3:0] STS_TOUCHED    = 4'd1;
  localparam logic [3:0] STS_ID_CHANGED = 4'd2;
  localparam logic [3:0] STS_ADDED      = 4'd3;
  localparam logic [3:0] STS_RESERVED   = 4'd4;
  localparam logic [3:0] STS_RES_FULL   = 4'd5;
  localparam logic [3:0] STS_PROMOTED   = 4'd6;
  localparam logic [3:0] STS_NO_ROOM    = 4'd7;
  localparam logic [3:0] STS_PING       = 4'd8;
  localparam logic [3:0] STS_NONE       = 4'd9;

  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_WAIT    = 1'b1;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] node_id;
    logic        id_known;
    logic [31:0] peer_ip;
    logic [15:0] peer_port;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [31:0] ping_ip;
    logic [15:0] ping_port;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] contact_timeout;
    logic [15:0] ping_wait;
  } cfg_t;

  typedef struct packed {
    logic [ID_BITS-1:0] id;
    logic               known;
    logic [31:0]        ip;
    logic [15:0]        port;
    logic [31:0]        seen;
    logic               pinged;
  } entry_t;

  typedef enum logic [1:0] {TOP_NONE, TOP_WRITE, TOP_REMOVE, TOP_ADD} tab_op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ACT_SCAN, ST_RES_SCAN, ST_PURGE, ST_ACT_PING, ST_RES_PING,
    ST_FINISH, ST_EMIT
  } state_t;

endpackage

// ===== design/routing_bucket_liveness_keeper.sv =====
// a tick bumps the clock and goes straight to its result; add and pong scan
// the active and then the reserve table, one entry per cycle
// a sweep purges, pings active then reserve entries; output stalls can hold it
// the engine takes one item at a time; a 2-item input queue takes items meanwhile
// reset: synchronous active low; clears clock, table counts and config to defaults
module routing_bucket_liveness_keeper (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rbk_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output rbk_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);
  import rbk_pkg::*;

  cfg_t      cfg_r;
  logic      q_valid, q_pop, emit, slot_free, out_valid_r;
  in_item_t  q_item;
  out_item_t emit_data, out_r;

  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  rbk_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_item,
    .q_valid, .q_item, .q_pop
  );

  rbk_engine u_engine (
    .clk, .rst_n, .q_valid, .q_item, .q_pop,
    .cfg(cfg_r), .slot_free, .emit, .emit_data
  );

  always_ff @(posedge clk) begin
    if (emit) out_r <= emit_data;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cfg_r       <= '{16'd120, 16'd20};
    end else begin
      if (emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (cfg_valid) begin
        if (cfg_index == CFG_TIMEOUT) cfg_r.contact_timeout <= cfg_data;
        else cfg_r.ping_wait <= cfg_data;
      end
    end
  end
endmodule

// ===== design/rbk_front.sv =====
module rbk_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rbk_pkg::in_item_t in_item,
  output logic              q_valid,
  output rbk_pkg::in_item_t q_item,
  input  logic              q_pop
);
  import rbk_pkg::*;

  in_item_t   buf_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = buf_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r] <= in_item;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

// ===== design/rbk_engine.sv =====
module rbk_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  rbk_pkg::in_item_t  q_item,
  output logic               q_pop,
  input  rbk_pkg::cfg_t      cfg,
  input  logic               slot_free,
  output logic               emit,
  output rbk_pkg::out_item_t emit_data
);
  import rbk_pkg::*;

  entry_t act_r [ACTIVE_SIZE];
  entry_t res_r [RESERVE_SIZE];

  state_t             state_r, state_nxt;
  in_item_t           item_r, item_nxt;
  logic [SCAN_W-1:0]  idx_r, idx_nxt;
  logic [ACNT_W-1:0]  need_r, need_nxt;
  logic [ACNT_W-1:0]  acnt_r, acnt_nxt;
  logic [RCNT_W-1:0]  rcnt_r, rcnt_nxt;
  logic [31:0]        sec_r, sec_nxt;
  logic               pend_v_r, pend_v_nxt;
  logic [47:0]        pend_r, pend_nxt;
  logic [3:0]         sts_r, sts_nxt;

  tab_op_t a_op, r_op;
  entry_t  a_wd, r_wd, a_rd, r_rd;
  logic [ID_BITS-1:0] in_id;
  logic [15:0] gap;
  logic [31:0] a_el, r_el;
  logic a_in, r_in, a_ep, r_ep, a_same, r_same, a_tmo, r_tmo;

  function automatic logic same_id(entry_t e, logic k, logic [ID_BITS-1:0] id);
    if (!e.known || !k) return e.known == k;
    return e.id == id;
  endfunction

  assign a_rd   = act_r[idx_r[AIDX_W-1:0]];
  assign r_rd   = res_r[idx_r[RIDX_W-1:0]];
  assign in_id  = item_r.id_known ? item_r.node_id[ID_BITS-1:0] : '0;
  assign gap    = (cfg.contact_timeout > cfg.ping_wait) ?
                  cfg.contact_timeout - cfg.ping_wait : 16'd0;
  assign a_el   = sec_r - a_rd.seen;
  assign r_el   = sec_r - r_rd.seen;
  assign a_in   = idx_r < SCAN_W'(acnt_r);
  assign r_in   = idx_r < SCAN_W'(rcnt_r);
  assign a_ep   = a_rd.ip == item_r.peer_ip && a_rd.port == item_r.peer_port;
  assign r_ep   = r_rd.ip == item_r.peer_ip && r_rd.port == item_r.peer_port;
  assign a_same = same_id(a_rd, item_r.id_known, in_id);
  assign r_same = same_id(r_rd, item_r.id_known, in_id);
  assign a_tmo  = a_rd.pinged && a_el > {16'd0, cfg.ping_wait};
  assign r_tmo  = r_rd.pinged && r_el > {16'd0, cfg.ping_wait};

  always_comb begin
    state_nxt  = state_r;
    item_nxt   = item_r;
    idx_nxt    = idx_r;
    need_nxt   = need_r;
    acnt_nxt   = acnt_r;
    rcnt_nxt   = rcnt_r;
    sec_nxt    = sec_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    sts_nxt    = sts_r;
    q_pop      = 1'b0;
    emit       = 1'b0;
    emit_data  = '0;
    a_op       = TOP_NONE;
    r_op       = TOP_NONE;
    a_wd       = a_rd;
    r_wd       = r_rd;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          item_nxt = q_item;
          idx_nxt  = '0;
          case (q_item.action)
            ACT_TICK: begin
              sec_nxt   = sec_r + 32'd1;
              sts_nxt   = STS_TICKED;
              state_nxt = ST_EMIT;
            end
            ACT_SWEEP: begin
              pend_v_nxt = 1'b0;
              state_nxt  = ST_PURGE;
            end
            default: state_nxt = ST_ACT_SCAN;
          endcase
        end
      end
      ST_ACT_SCAN: begin
        if (a_in) begin
          if (a_ep) begin
            if (a_same) begin
              a_op        = TOP_WRITE;
              a_wd.seen   = sec_r;
              a_wd.pinged = 1'b0;
              sts_nxt     = STS_TOUCHED;
            end else begin
              sts_nxt = STS_ID_CHANGED;
            end
            state_nxt = ST_EMIT;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end else begin
          idx_nxt   = '0;
          state_nxt = ST_RES_SCAN;
        end
      end
      ST_RES_SCAN: begin
        if (r_in) begin
          if (item_r.action == ACT_ADD) begin
            if (r_ep) begin
              sts_nxt   = STS_RESERVED;
              state_nxt = ST_EMIT;
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end else if (r_ep && (!r_rd.known || r_same)) begin
            if (acnt_r == ACNT_W'(ACTIVE_SIZE)) begin
              sts_nxt = STS_NO_ROOM;
            end else begin
              // promote to the front of the active table
              r_op        = TOP_REMOVE;
              rcnt_nxt    = rcnt_r - 1'b1;
              a_op        = TOP_ADD;
              a_wd        = r_rd;
              a_wd.id     = in_id;
              a_wd.known  = item_r.id_known;
              a_wd.seen   = sec_r;
              a_wd.pinged = 1'b0;
              acnt_nxt    = acnt_r + 1'b1;
              sts_nxt     = STS_PROMOTED;
            end
            state_nxt = ST_EMIT;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end else begin
          if (item_r.action == ACT_ADD) begin
            if (rcnt_r == RCNT_W'(RESERVE_SIZE)) begin
              sts_nxt = STS_RES_FULL;
            end else begin
              r_op        = TOP_ADD;
              r_wd.id     = in_id;
              r_wd.known  = item_r.id_known;
              r_wd.ip     = item_r.peer_ip;
              r_wd.port   = item_r.peer_port;
              r_wd.seen   = sec_r - {16'd0, cfg.contact_timeout};
              r_wd.pinged = 1'b0;
              rcnt_nxt    = rcnt_r + 1'b1;
              sts_nxt     = STS_ADDED;
            end
          end else begin
            sts_nxt = STS_NONE;
          end
          state_nxt = ST_EMIT;
        end
      end
      ST_PURGE: begin
        if (a_in) begin
          if (a_tmo) begin
            a_op     = TOP_REMOVE;
            acnt_nxt = acnt_r - 1'b1;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end else begin
          idx_nxt   = '0;
          state_nxt = ST_ACT_PING;
        end
      end
      ST_ACT_PING: begin
        if (a_in) begin
          if (!a_rd.pinged && a_el > {16'd0, gap}) begin
            // the held ping goes out once the next one is known
            if (!pend_v_r || slot_free) begin
              emit        = pend_v_r;
              emit_data   = '{STS_PING, pend_r[47:16], pend_r[15:0], 1'b0};
              pend_v_nxt  = 1'b1;
              pend_nxt    = {a_rd.ip, a_rd.port};
              a_op        = TOP_WRITE;
              a_wd.pinged = 1'b1;
              idx_nxt     = idx_r + 1'b1;
            end
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end else begin
          idx_nxt   = '0;
          need_nxt  = ACNT_W'(ACTIVE_SIZE) - acnt_r;
          state_nxt = ST_RES_PING;
        end
      end
      ST_RES_PING: begin
        if (r_in && need_r != '0) begin
          if (!r_rd.pinged) begin
            if (!pend_v_r || slot_free) begin
              emit        = pend_v_r;
              emit_data   = '{STS_PING, pend_r[47:16], pend_r[15:0], 1'b0};
              pend_v_nxt  = 1'b1;
              pend_nxt    = {r_rd.ip, r_rd.port};
              r_op        = TOP_WRITE;
              r_wd.pinged = 1'b1;
              r_wd.seen   = sec_r - {16'd0, gap};
              idx_nxt     = idx_r + 1'b1;
              need_nxt    = need_r - 1'b1;
            end
          end else if (r_tmo) begin
            r_op     = TOP_REMOVE;
            rcnt_nxt = rcnt_r - 1'b1;
            need_nxt = need_r - 1'b1;
          end else begin
            idx_nxt  = idx_r + 1'b1;
            need_nxt = need_r - 1'b1;
          end
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          emit = 1'b1;
          if (pend_v_r) emit_data = '{STS_PING, pend_r[47:16], pend_r[15:0], 1'b1};
          else emit_data = '{STS_NONE, 32'd0, 16'd0, 1'b1};
          pend_v_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_data = '{sts_r, 32'd0, 16'd0, 1'b1};
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < ACTIVE_SIZE; j++) begin
      case (a_op)
        TOP_WRITE: if (AIDX_W'(j) == idx_r[AIDX_W-1:0]) act_r[j] <= a_wd;
        TOP_REMOVE: begin
          if (j < ACTIVE_SIZE - 1 && SCAN_W'(j) >= idx_r) act_r[j] <= act_r[j+1];
        end
        TOP_ADD: begin
          if (j == 0) act_r[j] <= a_wd;
          else act_r[j] <= act_r[j-1];
        end
        default: ;
      endcase
    end
    for (int j = 0; j < RESERVE_SIZE; j++) begin
      case (r_op)
        TOP_WRITE: if (RIDX_W'(j) == idx_r[RIDX_W-1:0]) res_r[j] <= r_wd;
        TOP_REMOVE: begin
          if (j < RESERVE_SIZE - 1 && SCAN_W'(j) >= idx_r) res_r[j] <= res_r[j+1];
        end
        TOP_ADD: if (RCNT_W'(j) == rcnt_r) res_r[j] <= r_wd;
        default: ;
      endcase
    end
    item_r <= item_nxt;
    pend_r <= pend_nxt;
    sts_r  <= sts_nxt;
    need_r <= need_nxt;
    idx_r  <= idx_nxt;
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      acnt_r   <= '0;
      rcnt_r   <= '0;
      sec_r    <= '0;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      acnt_r   <= acnt_nxt;
      rcnt_r   <= rcnt_nxt;
      sec_r    <= sec_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end
endmodule
